>>> hw/rtl/fmr_pkg.sv
// ----------------------------------------------------------------------------
// fmr_pkg
// Shared types and constants of the framed message receiver.
// ----------------------------------------------------------------------------
package fmr_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned NUM_SRC  = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_BYTE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_A      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_B      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_C      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_D      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_E      = 3'd6;

   // register reset values
   localparam logic [BYTE_W-1:0] RST_START_BYTE = 8'h02;
   localparam logic [BYTE_W-1:0] RST_END_BYTE   = 8'h03;
   localparam logic [BYTE_W-1:0] RST_SRC_A      = 8'h41;
   localparam logic [BYTE_W-1:0] RST_SRC_B      = 8'h42;
   localparam logic [BYTE_W-1:0] RST_SRC_C      = 8'h43;
   localparam logic [BYTE_W-1:0] RST_SRC_D      = 8'h44;
   localparam logic [BYTE_W-1:0] RST_SRC_E      = 8'h45;

   localparam logic [BYTE_W-1:0] SUM_INIT = 8'hFF;

   typedef struct packed {
      logic [BYTE_W-1:0]               start_byte;
      logic [BYTE_W-1:0]               end_byte;
      logic [NUM_SRC-1:0][BYTE_W-1:0] source_codes;
   } cfg_type;

   typedef struct packed {
      logic              data_valid;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] data_index;
      logic              frame_error;
      logic              frame_done;
      logic [BYTE_W-1:0] sender_code;
      logic [BYTE_W-1:0] message_count;
   } result_type;

endpackage

>>> hw/rtl/fmr_channels.sv
// ----------------------------------------------------------------------------
// fmr_channels
// Valid/ready channels of the receiver: byte request and result response.
// ----------------------------------------------------------------------------
interface fmr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fmr_rsp_if;
   logic       valid;
   logic       ready;
   logic       data_valid;
   logic [7:0] data_byte;
   logic [7:0] data_index;
   logic       frame_error;
   logic       frame_done;
   logic [7:0] sender_code;
   logic [7:0] message_count;

   modport source (output valid, output data_valid, output data_byte, output data_index,
                   output frame_error, output frame_done, output sender_code,
                   output message_count, input ready);
   modport sink   (input valid, input data_valid, input data_byte, input data_index,
                   input frame_error, input frame_done, input sender_code,
                   input message_count, output ready);
endinterface

>>> hw/rtl/framed_message_receiver.sv
// ----------------------------------------------------------------------------
// framed_message_receiver
// Parses start/dest/source/count/length/data/checksum/end frames byte by byte.
// ----------------------------------------------------------------------------
//  port     dir   handshake     payload
//  req_ch   in    valid/ready   rx_byte
//  rsp_ch   out   valid/ready   data_valid, data_byte, data_index, frame_error,
//                               frame_done, sender_code, message_count
//  csr_*    in    csr_we        csr_index, csr_wdata (write only)
//
//  One transaction per cycle unless stalled; one registered response per byte.
//  The frame state advances in a single step from the state registers into
//  the response register. req_ch.ready is low only while a response waits.
//  Synchronous active-high reset; registers but rsp_ff return to defaults.
// ----------------------------------------------------------------------------
module framed_message_receiver #(
   parameter int unsigned MAX_MESSAGE_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   fmr_req_if.sink     req_ch,
   fmr_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   fmr_pkg::cfg_type    cfg_ff;
   fmr_pkg::result_type core_result;
   fmr_pkg::result_type rsp_ff;
   logic                rsp_valid_ff;
   logic                step;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign step         = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte      <= fmr_pkg::RST_START_BYTE;
         cfg_ff.end_byte        <= fmr_pkg::RST_END_BYTE;
         cfg_ff.source_codes[0] <= fmr_pkg::RST_SRC_A;
         cfg_ff.source_codes[1] <= fmr_pkg::RST_SRC_B;
         cfg_ff.source_codes[2] <= fmr_pkg::RST_SRC_C;
         cfg_ff.source_codes[3] <= fmr_pkg::RST_SRC_D;
         cfg_ff.source_codes[4] <= fmr_pkg::RST_SRC_E;
      end else if (csr_we) begin
         unique case (csr_index)
            fmr_pkg::CSR_START_BYTE: cfg_ff.start_byte      <= csr_wdata;
            fmr_pkg::CSR_END_BYTE:   cfg_ff.end_byte        <= csr_wdata;
            fmr_pkg::CSR_SRC_A:      cfg_ff.source_codes[0] <= csr_wdata;
            fmr_pkg::CSR_SRC_B:      cfg_ff.source_codes[1] <= csr_wdata;
            fmr_pkg::CSR_SRC_C:      cfg_ff.source_codes[2] <= csr_wdata;
            fmr_pkg::CSR_SRC_D:      cfg_ff.source_codes[3] <= csr_wdata;
            fmr_pkg::CSR_SRC_E:      cfg_ff.source_codes[4] <= csr_wdata;
            default: ;
         endcase
      end
   end

   fmr_core #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (req_ch.rx_byte),
      .cfg     (cfg_ff),
      .result  (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         rsp_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.data_valid    = rsp_ff.data_valid;
   assign rsp_ch.data_byte     = rsp_ff.data_byte;
   assign rsp_ch.data_index    = rsp_ff.data_index;
   assign rsp_ch.frame_error   = rsp_ff.frame_error;
   assign rsp_ch.frame_done    = rsp_ff.frame_done;
   assign rsp_ch.sender_code   = rsp_ff.sender_code;
   assign rsp_ch.message_count = rsp_ff.message_count;

`ifndef SYNTHESIS
   a_done_not_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.frame_done && rsp_ff.frame_error))
      else $error("frame reported both good and bad");
   a_done_not_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.frame_done && rsp_ff.data_valid))
      else $error("data byte flagged as frame end");
   a_accept_resp: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("accepted transaction produced no response");
`endif

endmodule

>>> hw/rtl/fmr_core.sv
// ----------------------------------------------------------------------------
// fmr_core
// Frame state, length, index and checksum; one byte step per transaction.
// ----------------------------------------------------------------------------
module fmr_core #(
   parameter int unsigned MAX_MESSAGE_BYTES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   input  fmr_pkg::cfg_type    cfg,
   output fmr_pkg::result_type result
);

   localparam int unsigned IDX_W = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam logic [15:0] LEN_LIMIT = 16'(MAX_MESSAGE_BYTES - 8);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_MESSAGE_BYTES);

   typedef enum logic [3:0] {
      PH_IDLE, PH_DEST, PH_SOURCE, PH_COUNT, PH_LEN_HI, PH_LEN_LO, PH_DATA, PH_SUM, PH_END
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] wi_ff, wi_in;
   logic [15:0]      len_ff, len_in;
   logic [7:0]       sum_ff, sum_in;
   logic             zero_ff, zero_in;
   logic [7:0]       sender_ff, sender_in;
   logic [7:0]       count_ff, count_in;

   logic [IDX_W-1:0] wi_inc;
   logic [IDX_W+7:0] wi_ext;
   logic [15:0]      len_lo;
   logic             src_ok;

   assign wi_inc = wi_ff + 1'b1;
   assign wi_ext = {8'b0, wi_ff};
   assign len_lo = {len_ff[15:8], rx_byte};

   always_comb begin
      src_ok = 1'b0;
      for (int i = 0; i < fmr_pkg::NUM_SRC; i++) begin
         if (cfg.source_codes[i] == rx_byte) src_ok = 1'b1;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      wi_in     = wi_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      zero_in   = zero_ff;
      sender_in = sender_ff;
      count_in  = count_ff;
      result    = '0;

      unique case (phase_ff)
         PH_IDLE: begin
            wi_in   = '0;
            len_in  = '0;
            sum_in  = fmr_pkg::SUM_INIT;
            zero_in = 1'b0;
            if (rx_byte == cfg.start_byte) phase_in = PH_DEST;
         end
         PH_DEST: phase_in = PH_SOURCE;
         PH_SOURCE: begin
            if (src_ok) begin
               sender_in = rx_byte;
               phase_in  = PH_COUNT;
            end else begin
               result.frame_error = 1'b1;
               phase_in           = PH_IDLE;
            end
         end
         PH_COUNT: begin
            count_in = rx_byte;
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            len_in   = {rx_byte, 8'h00};
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_in = len_lo;
            if (len_lo > LEN_LIMIT) begin
               result.frame_error = 1'b1;
               phase_in           = PH_IDLE;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            result.data_valid = 1'b1;
            result.data_byte  = rx_byte;
            result.data_index = wi_ext[7:0];
            if (!zero_ff) begin
               if (rx_byte == 8'h00) zero_in = 1'b1;
               else                  sum_in  = sum_ff + rx_byte;
            end
            wi_in = wi_inc;
            if (16'(wi_inc) >= len_ff || wi_inc >= IDX_MAX) begin
               phase_in = PH_SUM;
               wi_in    = '0;
            end
            // end byte overrides start byte
            if (rx_byte == cfg.start_byte) begin
               result.frame_error = 1'b1;
               phase_in           = PH_DEST;
            end
            if (rx_byte == cfg.end_byte) begin
               result.frame_error = 1'b1;
               phase_in           = PH_IDLE;
            end
         end
         PH_SUM: begin
            if (rx_byte != sum_ff) begin
               result.frame_error = 1'b1;
               phase_in           = PH_IDLE;
            end else begin
               phase_in = PH_END;
            end
         end
         PH_END: begin
            phase_in = PH_IDLE;
            if (rx_byte != cfg.end_byte) result.frame_error = 1'b1;
            else                         result.frame_done  = 1'b1;
         end
         default: phase_in = PH_IDLE;
      endcase

      result.sender_code   = sender_in;
      result.message_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         wi_ff     <= '0;
         len_ff    <= '0;
         sum_ff    <= fmr_pkg::SUM_INIT;
         zero_ff   <= 1'b0;
         sender_ff <= '0;
         count_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         wi_ff     <= wi_in;
         len_ff    <= len_in;
         sum_ff    <= sum_in;
         zero_ff   <= zero_in;
         sender_ff <= sender_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      wi_ff < IDX_MAX)
      else $error("write index out of range");
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> len_ff <= LEN_LIMIT)
      else $error("data phase entered with oversized length");
   a_idle_clears: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_IDLE |=> wi_ff == '0 && sum_ff == fmr_pkg::SUM_INIT && !zero_ff)
      else $error("idle byte did not clear frame state");
`endif

endmodule
